// ----- hw/rtl/bmor_pkg.sv -----
package bmor_pkg;

  // Line geometry.
  localparam int MaxWidth = 256;
  localparam int LineIdxW = $clog2(MaxWidth);
  localparam int EwW      = LineIdxW + 1;

  // Field and register widths.
  localparam int PixW    = 8;
  localparam int DimW    = 9;
  localparam int HeightW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;
  localparam int CmpW    = (DimW > EwW) ? DimW : EwW;

  localparam logic [PixW-1:0] FgLevel = 8'hFF;
  localparam logic [PixW-1:0] BgLevel = 8'h00;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd2;

  // Action codes.
  localparam logic ActPixel = 1'b0;
  localparam logic ActDrain = 1'b1;

  // Mode codes.
  localparam logic ModeErode  = 1'b0;
  localparam logic ModeDilate = 1'b1;

  // Result queue geometry.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;

  // One queued result beat.
  typedef struct packed {
    logic fg;
    logic done;
    logic last;
  } res_t;

  // Taps of the line buffer.
  typedef struct packed {
    logic at_col;
    logic next_col;
  } line_tap_t;

  // Erosion is an AND over the window, dilation an OR.
  function automatic logic win4(input logic mode, input logic a, input logic b,
                                input logic c, input logic d);
    logic r;
    if (mode == ModeErode) begin
      r = a & b & c & d;
    end else begin
      r = a | b | c | d;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bmor_cell.sv -----
module bmor_cell (
  input  logic clk_i,
  input  logic shift_i,
  input  logic bit_i,
  output logic bit_o
);

  logic bit_q;

  // Take the neighbor's bit on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      bit_q <= bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule

// ----- hw/rtl/bmor_line.sv -----
module bmor_line (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic                          bit_i,
  input  logic [bmor_pkg::LineIdxW-1:0] tap_sel_i,
  output bmor_pkg::line_tap_t           tap_o
);

  logic [bmor_pkg::MaxWidth-1:0] chain;
  logic [bmor_pkg::LineIdxW-1:0] next_sel;

  // Row of one-bit cells; cell k holds the bit shifted in k+1 beats ago.
  for (genvar k = 0; k < bmor_pkg::MaxWidth; k++) begin : g_cell
    if (k == 0) begin : g_head
      bmor_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift_i),
        .bit_i  (bit_i),
        .bit_o  (chain[k])
      );
    end else begin : g_body
      bmor_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift_i),
        .bit_i  (chain[k-1]),
        .bit_o  (chain[k])
      );
    end
  end

  // The bit one row old, and the one after it in the same row.
  assign next_sel       = tap_sel_i - bmor_pkg::LineIdxW'(1);
  assign tap_o.at_col   = chain[tap_sel_i];
  assign tap_o.next_col = chain[next_sel];

endmodule

// ----- hw/rtl/binary_morphology_2x2_unit.sv -----
// Streaming 2x2 binary erosion / dilation.
// Input channel: in_valid_i / in_stall_o carry action_i and pixel_in_i. A pixel
// beat (action 0) delivers the next raster pixel; 255 is foreground. After the
// last row is in, drain beats (action 1) give the last result row, one per beat.
// Output channel: out_valid_o / out_stall_i carry pixel_out_o (0 or 255),
// frame_done_o on the frame's final result and run_end_o on the last result
// caused by an input beat.
// Throughput: one input beat per cycle while in_stall_o is low. In every row
// after the first, a row of W pixels gives W results; for W above 1, none on its
// first beat and two on its last.
// Results pass through a four-entry queue, and in_stall_o rises once it holds
// three or more.
// When the receiver stalls, the queue fills and then stalls the input side.
// Reset clears the frame position, the queue and the registers (mode erosion,
// width 200, height 200). Writing width or height restarts the frame.
// Write configuration only while no beat is in flight; the block doesn't check.
module binary_morphology_2x2_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bmor_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bmor_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [bmor_pkg::PixW-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bmor_pkg::PixW-1:0]     pixel_out_o,
  output logic                          frame_done_o,
  output logic                          run_end_o
);

  // Configuration registers.
  logic                           mode_q;
  logic [bmor_pkg::DimW-1:0]      width_q;
  logic [bmor_pkg::HeightW-1:0]   height_q;

  // Frame position.
  logic [bmor_pkg::HeightW-1:0]   row_q, row_d;
  logic [bmor_pkg::LineIdxW-1:0]  col_q, col_d;
  logic [bmor_pkg::LineIdxW-1:0]  drain_q, drain_d;
  logic                           ul_q, ul_d;
  logic                           ll_q, ll_d;
  logic                           restart;

  // Effective geometry.
  logic [bmor_pkg::CmpW-1:0]      width_ext;
  logic [bmor_pkg::EwW-1:0]       eff_w;
  logic [bmor_pkg::LineIdxW-1:0]  wm1;
  logic [bmor_pkg::HeightW-1:0]   eff_h;
  logic                           pad;
  logic                           rows_in;

  // Item handling.
  logic                           accept;
  logic                           fg;
  logic                           pix_go;
  logic                           drain_go;
  logic                           shift;
  logic                           shift_bit;
  bmor_pkg::line_tap_t            tap;
  logic                           last_col;
  logic                           drain_last;
  logic                           r1_v, r2_v;
  logic                           r1_fg, r2_fg;
  logic [1:0]                     push_n;
  bmor_pkg::res_t                 e0, e1;

  // Result queue.
  bmor_pkg::res_t                 fifo_q [bmor_pkg::FifoDepth];
  logic [bmor_pkg::FifoPtrW-1:0]  wr_q, rd_q;
  logic [bmor_pkg::FifoCntW-1:0]  cnt_q;
  logic                           pop;
  bmor_pkg::res_t                 head;

  // Width 0 acts as 1, widths above the line length act as the line length.
  assign width_ext = bmor_pkg::CmpW'(width_q);
  always_comb begin
    if (width_ext == '0) begin
      eff_w = bmor_pkg::EwW'(1);
    end else if (width_ext > bmor_pkg::CmpW'(bmor_pkg::MaxWidth)) begin
      eff_w = bmor_pkg::EwW'(bmor_pkg::MaxWidth);
    end else begin
      eff_w = bmor_pkg::EwW'(width_ext);
    end
  end
  assign wm1     = bmor_pkg::LineIdxW'(eff_w - bmor_pkg::EwW'(1));
  assign eff_h   = (height_q == '0) ? bmor_pkg::HeightW'(1) : height_q;
  assign pad     = (mode_q == bmor_pkg::ModeErode);
  assign rows_in = (row_q >= eff_h);

  // Configuration writes.
  assign restart = cfg_we_i && (cfg_idx_i == bmor_pkg::CfgWidth ||
                                cfg_idx_i == bmor_pkg::CfgHeight);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bmor_pkg::ModeErode;
      width_q  <= bmor_pkg::DimW'(200);
      height_q <= bmor_pkg::HeightW'(200);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bmor_pkg::CfgMode:   mode_q   <= cfg_data_i[0];
        bmor_pkg::CfgWidth:  width_q  <= cfg_data_i[bmor_pkg::DimW-1:0];
        bmor_pkg::CfgHeight: height_q <= cfg_data_i[bmor_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Item decode.
  assign accept   = in_valid_i && !in_stall_o;
  assign fg       = (pixel_in_i == bmor_pkg::FgLevel);
  assign pix_go   = accept && (action_i == bmor_pkg::ActPixel) && !rows_in;
  assign drain_go = accept && (action_i == bmor_pkg::ActDrain) && rows_in;
  assign shift    = pix_go || drain_go;
  assign shift_bit = pix_go ? fg : 1'b0;

  // Line buffer: the tap one row back gives the upper neighbor.
  bmor_line u_line (
    .clk_i    (clk_i),
    .shift_i  (shift),
    .bit_i    (shift_bit),
    .tap_sel_i(wm1),
    .tap_o    (tap)
  );

  // Window results for the current item.
  assign last_col   = (col_q == wm1);
  assign drain_last = (drain_q == wm1);
  assign r1_fg = bmor_pkg::win4(mode_q, ul_q, tap.at_col, ll_q, fg);
  assign r2_fg = bmor_pkg::win4(mode_q, tap.at_col, pad, fg, pad);
  assign r1_v  = pix_go && (row_q != '0) && (col_q != '0);
  assign r2_v  = pix_go && (row_q != '0) && last_col;

  always_comb begin
    e0     = '0;
    e1     = '0;
    push_n = 2'd0;
    if (drain_go) begin
      e0.fg   = bmor_pkg::win4(mode_q, tap.at_col,
                               drain_last ? pad : tap.next_col, pad, pad);
      e0.done = drain_last;
      e0.last = 1'b1;
      push_n  = 2'd1;
    end else if (r1_v && r2_v) begin
      e0.fg   = r1_fg;
      e1.fg   = r2_fg;
      e1.last = 1'b1;
      push_n  = 2'd2;
    end else if (r1_v) begin
      e0.fg   = r1_fg;
      e0.last = 1'b1;
      push_n  = 2'd1;
    end else if (r2_v) begin
      e0.fg   = r2_fg;
      e0.last = 1'b1;
      push_n  = 2'd1;
    end
  end

  // Next frame position.
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    drain_d = drain_q;
    ul_d    = ul_q;
    ll_d    = ll_q;
    if (restart) begin
      row_d   = '0;
      col_d   = '0;
      drain_d = '0;
      ul_d    = 1'b0;
      ll_d    = 1'b0;
    end else if (pix_go) begin
      if (last_col) begin
        col_d = '0;
        row_d = row_q + bmor_pkg::HeightW'(1);
        ul_d  = 1'b0;
        ll_d  = 1'b0;
      end else begin
        col_d = col_q + bmor_pkg::LineIdxW'(1);
        ul_d  = tap.at_col;
        ll_d  = fg;
      end
    end else if (drain_go) begin
      if (drain_last) begin
        row_d   = '0;
        col_d   = '0;
        drain_d = '0;
        ul_d    = 1'b0;
        ll_d    = 1'b0;
      end else begin
        drain_d = drain_q + bmor_pkg::LineIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      drain_q <= '0;
      ul_q    <= 1'b0;
      ll_q    <= 1'b0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      drain_q <= drain_d;
      ul_q    <= ul_d;
      ll_q    <= ll_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_q] <= e0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_q + bmor_pkg::FifoPtrW'(1)] <= e1;
    end
  end

  // Result queue pointers and fill count.
  assign pop = out_valid_o && !out_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + bmor_pkg::FifoPtrW'(push_n);
      rd_q  <= rd_q + bmor_pkg::FifoPtrW'(pop);
      cnt_q <= cnt_q + bmor_pkg::FifoCntW'(push_n) - bmor_pkg::FifoCntW'(pop);
    end
  end

  // Room for two results is needed before a beat is taken.
  assign in_stall_o = (cnt_q > bmor_pkg::FifoCntW'(bmor_pkg::FifoDepth - 2));

  assign head         = fifo_q[rd_q];
  assign out_valid_o  = (cnt_q != '0);
  assign pixel_out_o  = head.fg ? bmor_pkg::FgLevel : bmor_pkg::BgLevel;
  assign frame_done_o = head.done;
  assign run_end_o    = head.last;

  // The queue never overflows.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bmor_pkg::FifoCntW'(bmor_pkg::FifoDepth))
    else $error("result queue overflow");

  // The column stays inside the effective row.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wm1)
    else $error("column beyond row end");

  // The frame's final result also closes its run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> run_end_o)
    else $error("frame end without run end");

  // The drain column only moves once all rows are in.
  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rows_in |-> drain_q == '0)
    else $error("drain column moved while rows pending");

endmodule

// ----- sim/tb_binary_morphology_2x2_unit.sv -----
module tb_binary_morphology_2x2_unit;

  import bmor_pkg::*;

  // One expected result beat.
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            done;
    logic            last;
  } morph_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                action_i;
  logic [PixW-1:0]     pixel_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PixW-1:0]     pixel_out_o;
  logic                frame_done_o;
  logic                run_end_o;

  binary_morphology_2x2_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_done_o (frame_done_o),
    .run_end_o    (run_end_o)
  );

  // Shadow copy of the block's registers and frame position.
  logic              m_mode   = ModeErode;
  logic [DimW-1:0]   m_width  = 9'd200;
  logic [HeightW-1:0] m_height = 16'd200;
  logic              m_line [MaxWidth];
  logic              m_ul     = 1'b0;
  logic              m_ll     = 1'b0;
  int unsigned       m_rows   = 0;
  int unsigned       m_col    = 0;
  int unsigned       m_drain  = 0;

  morph_res_t pending_results[$];
  int         err_count  = 0;
  int         burst_left = 0;

  initial begin
    foreach (m_line[i]) m_line[i] = 1'b0;
  end

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver stall pattern: it switches between several styles every so often.
  initial begin
    int style;
    int style_left;
    int cyc;
    style = 0;
    style_left = 0;
    cyc = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      cyc++;
      case (style)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(0, 3) == 0);
        2: out_stall_i = ($urandom_range(0, 3) != 0);
        default: out_stall_i = ((cyc % 12) < 8);
      endcase
    end
  end

  function automatic logic win2x2(input logic a, input logic b, input logic c, input logic d);
    if (m_mode == ModeErode) begin
      return a & b & c & d;
    end
    return a | b | c | d;
  endfunction

  function automatic morph_res_t mk_res(input logic fg, input logic done);
    morph_res_t r;
    r.pix  = fg ? FgLevel : BgLevel;
    r.done = done;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void restart_frame();
    m_rows  = 0;
    m_col   = 0;
    m_drain = 0;
    m_ul    = 1'b0;
    m_ll    = 1'b0;
  endfunction

  // Works out the results of one accepted beat and queues them.
  function automatic void apply_beat(input logic act, input logic [PixW-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int          n;
    logic        cur;
    logic        pad;
    logic        up;
    logic        nb;
    logic        done;
    morph_res_t  r [2];
    w = (m_width == 0) ? 1 : ((m_width > MaxWidth) ? MaxWidth : m_width);
    h = (m_height == 0) ? 1 : m_height;
    cur = (pix == FgLevel);
    pad = (m_mode == ModeErode);
    n = 0;
    if (act == ActDrain) begin
      // Drains only count once every row is in.
      if (m_rows >= h) begin
        c = (m_drain >= w) ? w - 1 : m_drain;
        nb = (c + 1 < w) ? m_line[c + 1] : pad;
        done = (c + 1 >= w);
        r[0] = mk_res(win2x2(m_line[c], nb, pad, pad), done);
        n = 1;
        if (done) begin
          restart_frame();
        end else begin
          m_drain = c + 1;
        end
      end
    end else if (m_rows < h) begin
      c = (m_col >= w) ? w - 1 : m_col;
      up = m_line[c];
      if (m_rows > 0) begin
        if (c > 0) begin
          r[n] = mk_res(win2x2(m_ul, up, m_ll, cur), 1'b0);
          n = n + 1;
        end
        if (c == w - 1) begin
          r[n] = mk_res(win2x2(up, pad, cur, pad), 1'b0);
          n = n + 1;
        end
      end
      m_ul = up;
      m_ll = cur;
      m_line[c] = cur;
      if (c + 1 >= w) begin
        m_col = 0;
        m_rows++;
        m_ul = 1'b0;
        m_ll = 1'b0;
      end else begin
        m_col = c + 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      r[i].last = (i == n - 1);
      pending_results.push_back(r[i]);
    end
  endfunction

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    morph_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got pixel_out %0d %s",
                 $time, pixel_out_o,
                 $sformatf("frame_done %0b run_end %0b", frame_done_o, run_end_o));
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (pixel_out_o !== want.pix) begin
          $display("%0t: pixel_out expected %0d, got %0d", $time, want.pix, pixel_out_o);
          err_count++;
        end
        if (frame_done_o !== want.done) begin
          $display("%0t: frame_done expected %0b, got %0b", $time, want.done, frame_done_o);
          err_count++;
        end
        if (run_end_o !== want.last) begin
          $display("%0t: run_end expected %0b, got %0b", $time, want.last, run_end_o);
          err_count++;
        end
      end
    end
  end

  // Sends one beat; the sender works in bursts with random gaps between them.
  task automatic send_beat(input logic act, input logic [PixW-1:0] pix);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    action_i   = act;
    pixel_in_i = pix;
    do @(posedge clk_i); while (in_stall_o);
    apply_beat(act, pix);
  endtask

  // Stops sending and waits until every expected result has come out.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic load_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    if (idx == CfgMode) begin
      m_mode = data[0];
    end else if (idx == CfgWidth) begin
      m_width = data[DimW-1:0];
      restart_frame();
    end else if (idx == CfgHeight) begin
      m_height = data[HeightW-1:0];
      restart_frame();
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly clean foreground or background, sometimes any level.
  function automatic logic [PixW-1:0] rand_pixel();
    if ($urandom_range(0, 9) < 7) begin
      return $urandom_range(0, 1) ? FgLevel : BgLevel;
    end
    return PixW'($urandom_range(0, 255));
  endfunction

  // Short hand-picked frames: defaults, tiny sizes, ignored beats, mode switch.
  task automatic test_directed();
    // A few pixels under the reset settings; the first row gives nothing.
    send_beat(ActPixel, FgLevel);
    send_beat(ActPixel, 8'd0);
    send_beat(ActPixel, 8'd254);
    wait_quiet();
    // 2x2 erosion, with an early drain and a late pixel that are both ignored.
    load_reg(CfgMode, CfgW'(ModeErode));
    load_reg(CfgWidth, 16'd2);
    load_reg(CfgHeight, 16'd2);
    send_beat(ActPixel, FgLevel);
    send_beat(ActPixel, FgLevel);
    send_beat(ActDrain, 8'd0);
    send_beat(ActPixel, FgLevel);
    send_beat(ActPixel, 8'd254);
    send_beat(ActPixel, FgLevel);
    send_beat(ActDrain, 8'd255);
    send_beat(ActDrain, 8'd1);
    wait_quiet();
    // Zero width and zero height act as one.
    load_reg(CfgMode, CfgW'(ModeDilate));
    load_reg(CfgWidth, 16'd0);
    load_reg(CfgHeight, 16'd0);
    send_beat(ActPixel, FgLevel);
    send_beat(ActDrain, 8'd128);
    wait_quiet();
    // Single column, two rows.
    load_reg(CfgHeight, 16'd2);
    load_reg(CfgWidth, 16'd1);
    send_beat(ActPixel, 8'd0);
    send_beat(ActPixel, FgLevel);
    send_beat(ActDrain, 8'd0);
    wait_quiet();
    // Mode switched between the rows of one frame.
    load_reg(CfgMode, CfgW'(ModeErode));
    load_reg(CfgWidth, 16'd3);
    send_beat(ActPixel, FgLevel);
    send_beat(ActPixel, 8'd0);
    send_beat(ActPixel, FgLevel);
    wait_quiet();
    load_reg(CfgMode, CfgW'(ModeDilate));
    send_beat(ActPixel, 8'd0);
    send_beat(ActPixel, 8'd0);
    send_beat(ActPixel, 8'd0);
    send_beat(ActDrain, 8'd0);
    send_beat(ActDrain, 8'd0);
    send_beat(ActDrain, 8'd0);
    wait_quiet();
  endtask

  // Largest width, oversize width, and the tallest frame cut short.
  task automatic test_extreme_sizes();
    // Tall frame: a few rows, an ignored drain, then a restart by a width write.
    load_reg(CfgMode, CfgW'(ModeErode));
    load_reg(CfgWidth, 16'd4);
    load_reg(CfgHeight, 16'hFFFF);
    for (int k = 0; k < 12; k++) send_beat(ActPixel, rand_pixel());
    send_beat(ActDrain, 8'd0);
    wait_quiet();
    // One row over the full line buffer, then the start of its drain.
    load_reg(CfgMode, CfgW'(ModeDilate));
    load_reg(CfgWidth, 16'd256);
    load_reg(CfgHeight, 16'd1);
    for (int k = 0; k < MaxWidth; k++) begin
      send_beat(ActPixel, ($urandom_range(0, 15) == 0) ? FgLevel : BgLevel);
    end
    for (int k = 0; k < 16; k++) send_beat(ActDrain, PixW'($urandom_range(0, 255)));
    wait_quiet();
    // Width above the maximum acts as the maximum; a full row, then part of a second.
    load_reg(CfgMode, CfgW'(ModeErode));
    load_reg(CfgWidth, 16'd511);
    load_reg(CfgHeight, 16'd2);
    for (int k = 0; k < MaxWidth + 16; k++) begin
      send_beat(ActPixel, ($urandom_range(0, 15) == 0) ? BgLevel : FgLevel);
    end
    wait_quiet();
  endtask

  // Random small frames with some noise beats and some frames cut short.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned total;
    int unsigned cut;
    int unsigned r;
    sent = 0;
    while (sent < 260) begin
      wait_quiet();
      if ($urandom_range(0, 1)) load_reg(CfgMode, CfgW'($urandom_range(0, 1)));
      r = $urandom_range(0, 19);
      w = (r == 0) ? 0 : ((r < 3) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      load_reg(CfgWidth, CfgW'(w));
      load_reg(CfgHeight, CfgW'(h));
      eff_w = (w == 0) ? 1 : w;
      eff_h = (h == 0) ? 1 : h;
      total = eff_w * eff_h;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
      for (int unsigned k = 0; k < cut; k++) begin
        // A drain while pixels are still expected is ignored.
        if ($urandom_range(0, 15) == 0) send_beat(ActDrain, PixW'($urandom_range(0, 255)));
        send_beat(ActPixel, rand_pixel());
        sent++;
        if ($urandom_range(0, 63) == 0) wait_quiet();
      end
      if (cut == total) begin
        for (int unsigned k = 0; k < eff_w; k++) begin
          // A pixel while the last row waits is ignored.
          if ($urandom_range(0, 15) == 0) send_beat(ActPixel, rand_pixel());
          send_beat(ActDrain, PixW'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgMode;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i   = ActPixel;
    pixel_in_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_extreme_sizes();
    test_random_frames();
    wait_quiet();
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
